// ===== hw/rtl/bst_pkg.sv =====
// Shared constants, operation codes and interface types for the bounded set table.
package bst_pkg;

   localparam int CAPACITY = 128;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 8;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W   = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   // Access request from the sequencer to the entry memory.
   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } mem_req_type;

   // Finished outcome of one transaction.
   typedef struct packed {
      logic              done_res;
      logic              full_reject;
      logic [FILL_W-1:0] fill;
   } result_type;

endpackage

// ===== hw/rtl/bounded_set_table_top.sv =====
// Top level of the bounded set table: sequencer, entry memory and response register.
//
// Keeps a set of up to CAPACITY distinct 32-bit values. Each request transaction
// (req_valid/req_ready) carries req_func (lookup, insert, delete, clear) and
// req_value. Each request yields exactly one response transaction
// (rsp_valid/rsp_ready) with done_res, full_reject, the element count and an
// empty flag.
// A clear empties the set without reading the entry memory. Other operations scan
// the stored entries one per cycle through the single read port of the entry
// memory. A hit ends the scan early; a delete that moves the last entry into the
// freed slot takes an extra move step but never needs the full scan.
// The sequencer works on one transaction at a time; req_ready is high only while
// the sequencer is idle, so the next request can be taken in the cycle after the
// response register loads.
// Reset clears the element count; the entry memory is not cleared, since only
// slots below the count are ever read.
// When the receiver stalls, the response register holds its transaction and the
// next request may still be accepted and worked on; it waits in the sequencer
// until the response register frees.
module bounded_set_table_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_func,
   input  logic signed [bst_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_done_res,
   output logic                                rsp_full_reject,
   output logic [bst_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                rsp_is_empty
);

   bst_pkg::mem_req_type            mem_req;
   logic [bst_pkg::VALUE_W-1:0]     rd_data;
   logic                            res_valid;
   logic                            res_ready;
   bst_pkg::result_type             res;

   logic                            rsp_valid_ff;
   logic                            done_res_ff;
   logic                            full_reject_ff;
   logic [bst_pkg::COUNT_W-1:0]     count_ff;
   logic                            is_empty_ff;

   bst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_value (req_value),
      .rd_data   (rd_data),
      .mem_req   (mem_req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   bst_ram u_ram (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (rd_data)
   );

   // Load the response register when it is empty or being drained this cycle.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid && res_ready) begin
         done_res_ff    <= res.done_res;
         full_reject_ff <= res.full_reject;
         count_ff       <= bst_pkg::COUNT_W'(res.fill);
         is_empty_ff    <= (res.fill == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_done_res    = done_res_ff;
   assign rsp_full_reject = full_reject_ff;
   assign rsp_count       = count_ff;
   assign rsp_is_empty    = is_empty_ff;

endmodule

// ===== hw/rtl/bst_ram.sv =====
// Entry memory: one write port, one read port, registered read data.
module bst_ram (
   input  logic                                clock,
   input  bst_pkg::mem_req_type                mem_req,
   output logic [bst_pkg::VALUE_W-1:0]         rd_data_ff
);

   logic [bst_pkg::VALUE_W-1:0] mem [bst_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

endmodule

// ===== hw/rtl/bst_ctrl.sv =====
// Sequencer: scans the entry memory, then inserts, deletes or reports membership; a clear empties the set.
module bst_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [bst_pkg::VALUE_W-1:0]   req_value,
   input  logic [bst_pkg::VALUE_W-1:0]   rd_data,
   output bst_pkg::mem_req_type          mem_req,
   output logic                          res_valid,
   input  logic                          res_ready,
   output bst_pkg::result_type           res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE,
      ST_MOVE,
      ST_FINISH
   } state_type;

   state_type                     state_ff, state_in;
   bst_pkg::func_type             func_ff, func_in;
   logic [bst_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic [bst_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic [bst_pkg::IDX_W-1:0]     cmp_ff, cmp_in;
   logic                          found_ff, found_in;
   logic                          done_ff, done_in;
   logic                          full_ff, full_in;
   logic [bst_pkg::IDX_W-1:0]     last_idx;

   assign last_idx  = bst_pkg::IDX_W'(fill_ff - bst_pkg::FILL_W'(1));
   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_FINISH);
   assign res.done_res    = done_ff;
   assign res.full_reject = full_ff;
   assign res.fill        = fill_ff;

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      value_in = value_ff;
      fill_in  = fill_ff;
      cmp_in   = cmp_ff;
      found_in = found_ff;
      done_in  = done_ff;
      full_in  = full_ff;
      mem_req  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = bst_pkg::func_type'(req_func);
               value_in = req_value;
               found_in = 1'b0;
               done_in  = 1'b0;
               full_in  = 1'b0;
               cmp_in   = '0;
               if (bst_pkg::func_type'(req_func) == bst_pkg::FUNC_CLEAR) begin
                  fill_in  = '0;
                  state_in = ST_FINISH;
               end else if (fill_ff == '0) begin
                  state_in = ST_RESOLVE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // rd_data holds the entry at cmp_ff
            if (rd_data == value_ff) begin
               found_in = 1'b1;
               state_in = ST_RESOLVE;
            end else if (cmp_ff == last_idx) begin
               state_in = ST_RESOLVE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cmp_ff + bst_pkg::IDX_W'(1);
               cmp_in          = cmp_ff + bst_pkg::IDX_W'(1);
            end
         end
         ST_RESOLVE: begin
            state_in = ST_FINISH;
            unique case (func_ff)
               bst_pkg::FUNC_LOOKUP: begin
                  done_in = found_ff;
               end
               bst_pkg::FUNC_INSERT: begin
                  if (!found_ff) begin
                     if (fill_ff < bst_pkg::FILL_W'(bst_pkg::CAPACITY)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = bst_pkg::IDX_W'(fill_ff);
                        mem_req.wr_data = value_ff;
                        fill_in         = fill_ff + bst_pkg::FILL_W'(1);
                        done_in         = 1'b1;
                     end else begin
                        full_in = 1'b1;
                     end
                  end
               end
               bst_pkg::FUNC_DELETE: begin
                  if (found_ff) begin
                     if (cmp_ff == last_idx) begin
                        fill_in = fill_ff - bst_pkg::FILL_W'(1);
                        done_in = 1'b1;
                     end else begin
                        // fetch the last entry to fill the hole
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = last_idx;
                        state_in        = ST_MOVE;
                     end
                  end
               end
               bst_pkg::FUNC_CLEAR: begin
                  done_in = 1'b0;
               end
            endcase
         end
         ST_MOVE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cmp_ff;
            mem_req.wr_data = rd_data;
            fill_in         = fill_ff - bst_pkg::FILL_W'(1);
            done_in         = 1'b1;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      func_ff  <= func_in;
      value_ff <= value_in;
      cmp_ff   <= cmp_in;
      found_ff <= found_in;
      done_ff  <= done_in;
      full_ff  <= full_in;
   end

endmodule

// ===== tb/bounded_set_table_checker.sv =====
// Scoreboard for the bounded set table: mirrors the set contents and checks every response.
module bounded_set_table_checker
   import bst_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic [VALUE_W-1:0]         req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_done_res,
   input  logic                       rsp_full_reject,
   input  logic [COUNT_W-1:0]         rsp_count,
   input  logic                       rsp_is_empty,
   output int                         mismatch_count,
   output int                         outstanding,
   output int                         results_checked,
   output int                         full_rejects,
   output int                         peak_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               done_res;
      logic               full_reject;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } set_outcome_type;

   logic [VALUE_W-1:0] members [CAPACITY];
   int                 member_count;
   set_outcome_type    pending_outcomes [$];

   // Apply one operation to the mirrored set and return the response it must produce.
   function automatic set_outcome_type apply_set_op(func_type op, logic [VALUE_W-1:0] val);
      set_outcome_type o;
      int              slot;
      o    = '0;
      slot = -1;
      for (int i = 0; i < member_count; i++) begin
         if (slot < 0 && members[i] == val) begin
            slot = i;
         end
      end
      case (op)
         FUNC_LOOKUP: begin
            o.done_res = (slot >= 0);
         end
         FUNC_INSERT: begin
            if (slot < 0) begin
               if (member_count < CAPACITY) begin
                  members[member_count] = val;
                  member_count++;
                  o.done_res = 1'b1;
               end else begin
                  o.full_reject = 1'b1;
               end
            end
         end
         FUNC_DELETE: begin
            if (slot >= 0) begin
               members[slot] = members[member_count - 1];
               member_count--;
               o.done_res = 1'b1;
            end
         end
         default: begin
            member_count = 0;
         end
      endcase
      o.count    = COUNT_W'(member_count);
      o.is_empty = (member_count == 0);
      return o;
   endfunction

   always @(posedge clock) begin : watch
      set_outcome_type want;
      if (reset) begin
         member_count = 0;
         pending_outcomes.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("response with no request waiting: done_res %0d count %0d",
                      rsp_done_res, rsp_count);
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               results_checked++;
               if (want.full_reject) begin
                  full_rejects++;
               end
               if (rsp_done_res !== want.done_res) begin
                  $error("done_res mismatch: expected %0d, actual %0d",
                         want.done_res, rsp_done_res);
                  mismatch_count++;
               end
               if (rsp_full_reject !== want.full_reject) begin
                  $error("full_reject mismatch: expected %0d, actual %0d",
                         want.full_reject, rsp_full_reject);
                  mismatch_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count mismatch: expected %0d, actual %0d", want.count, rsp_count);
                  mismatch_count++;
               end
               if (rsp_is_empty !== want.is_empty) begin
                  $error("is_empty mismatch: expected %0d, actual %0d",
                         want.is_empty, rsp_is_empty);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_outcomes.push_back(apply_set_op(func_type'(req_func), req_value));
         end
         if (member_count > peak_count) begin
            peak_count = member_count;
         end
         outstanding <= pending_outcomes.size();
      end
   end

endmodule

// ===== tb/tb_bounded_set_table_top.sv =====
// Testbench top for the bounded set table: clock, reset, stimulus, back-pressure and verdict.
module tb_bounded_set_table_top;
   import bst_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TOTAL = 1600;
   localparam int POOL_SIZE  = 160;   // more than CAPACITY, so growth runs hit a full table
   localparam int LONG_HOLD  = 400;
   localparam int END_SETTLE = 2 * CAPACITY;

   // Flavors of random traffic; each segment leans the operation mix one way.
   typedef enum int {
      MIX_GROW,
      MIX_CHURN,
      MIX_SHRINK
   } mix_kind_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   func_type                   req_func;
   logic signed [VALUE_W-1:0]  req_value;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_done_res;
   logic                       rsp_full_reject;
   logic [COUNT_W-1:0]         rsp_count;
   logic                       rsp_is_empty;

   int                         mismatch_count;
   int                         outstanding;
   int                         results_checked;
   int                         full_rejects;
   int                         peak_count;

   // Pacing knobs shared between the sender and the receiver processes.
   int                         sender_idle_pct;
   int                         receiver_idle_pct;
   int                         holdoff_asks;
   int                         items_sent;
   int                         op_tally [4];
   logic [VALUE_W-1:0]         value_pool [POOL_SIZE];

   always #5 clock = ~clock;

   bounded_set_table_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_done_res    (rsp_done_res),
      .rsp_full_reject (rsp_full_reject),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   bounded_set_table_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_done_res    (rsp_done_res),
      .rsp_full_reject (rsp_full_reject),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .full_rejects    (full_rejects),
      .peak_count      (peak_count)
   );

   // Offer one transaction: idle a random number of cycles first, then hold valid and
   // payload steady until the handshake. Valid is left high afterwards so that a
   // back-to-back transaction never sees it drop and rise within one time step.
   task automatic send_item(input func_type f, input logic [VALUE_W-1:0] v);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      op_tally[int'(f)]++;
   endtask

   // Stop offering and wait until every predicted response has been checked. The
   // first edge lets the checker's outstanding count catch up with the last handshake.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Receiver: random ready with the current idle rate, and a long hold-off whenever
   // the stimulus asks for one, so the response register and then the request side back up.
   initial begin : receiver
      int holdoffs_done;
      holdoffs_done = 0;
      rsp_ready     = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoffs_done != holdoff_asks) begin
            holdoffs_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   initial begin : stimulus
      mix_kind_type       mix;
      int                 seg_len;
      int                 r;
      int                 pace_phase;
      func_type           f;
      logic [VALUE_W-1:0] v;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = FUNC_LOOKUP;
      req_value         = '0;
      sender_idle_pct   = 29;
      receiver_idle_pct = 56;
      holdoff_asks      = 0;
      items_sent        = 0;
      pace_phase        = 0;
      foreach (op_tally[i]) op_tally[i] = 0;

      // Seed the value pool with the sign and range extremes, then random patterns.
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table behavior, extremes, duplicates, both delete paths, clear.
      send_item(FUNC_LOOKUP, 32'h0000_0000);   // lookup on an empty table
      send_item(FUNC_DELETE, 32'h0000_0000);   // delete on an empty table
      send_item(FUNC_INSERT, 32'h8000_0000);
      send_item(FUNC_INSERT, 32'h7FFF_FFFF);
      send_item(FUNC_INSERT, 32'h0000_0000);
      send_item(FUNC_INSERT, 32'hFFFF_FFFF);
      send_item(FUNC_INSERT, 32'h7FFF_FFFF);   // already present: no change
      send_item(FUNC_LOOKUP, 32'h8000_0000);
      send_item(FUNC_LOOKUP, 32'hFFFF_FFFF);
      send_item(FUNC_LOOKUP, 32'h0000_0001);   // absent
      send_item(FUNC_LOOKUP, 32'h7FFF_FFFE);   // absent, one off an entry
      send_item(FUNC_DELETE, 32'h0000_0001);   // delete of an absent value
      send_item(FUNC_DELETE, 32'h8000_0000);   // first slot: last entry moves in
      send_item(FUNC_LOOKUP, 32'hFFFF_FFFF);   // moved entry still found
      send_item(FUNC_DELETE, 32'h0000_0000);   // last live entry: nothing moves
      send_item(FUNC_LOOKUP, 32'h0000_0000);
      send_item(FUNC_CLEAR,  32'h0000_0000);
      send_item(FUNC_LOOKUP, 32'h7FFF_FFFF);   // gone after clear
      send_item(FUNC_CLEAR,  32'hFFFF_FFFF);   // clear an already empty table
      send_item(FUNC_INSERT, 32'h5555_5555);
      send_item(FUNC_INSERT, 32'hAAAA_AAAA);
      send_item(FUNC_DELETE, 32'hAAAA_AAAA);
      send_item(FUNC_DELETE, 32'h5555_5555);   // empties the table by delete
      drain_results();

      // Fill to capacity with distinct values and push past it, then re-insert a
      // present value while full (no refusal) and look for a refused one.
      for (int i = 0; i < CAPACITY + 8; i++) send_item(FUNC_INSERT, value_pool[i]);
      send_item(FUNC_INSERT, value_pool[3]);
      send_item(FUNC_LOOKUP, value_pool[CAPACITY + 2]);
      // Stall the receiver while the table is full.
      holdoff_asks++;

      // Random segments of skewed operation mixes over the value pool.
      while (items_sent < ITEM_TOTAL) begin
         // Advance the pacing phase: swap idle rates, then run with no idling apart from one more long hold-off.
         if (pace_phase == 0 && items_sent >= ITEM_TOTAL / 3) begin
            drain_results();
            pace_phase        = 1;
            sender_idle_pct   = 56;
            receiver_idle_pct = 29;
         end else if (pace_phase == 1 && items_sent >= 2 * ITEM_TOTAL / 3) begin
            drain_results();
            pace_phase        = 2;
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
            holdoff_asks++;
         end
         mix     = mix_kind_type'($urandom_range(2));
         seg_len = $urandom_range(40, 160);
         repeat (seg_len) begin
            r = $urandom_range(99);
            case (mix)
               MIX_GROW: begin
                  f = (r < 70) ? FUNC_INSERT : (r < 85) ? FUNC_LOOKUP : FUNC_DELETE;
               end
               MIX_SHRINK: begin
                  f = (r < 65) ? FUNC_DELETE : (r < 80) ? FUNC_LOOKUP : FUNC_INSERT;
               end
               default: begin
                  f = (r < 40) ? FUNC_INSERT : (r < 70) ? FUNC_LOOKUP :
                      (r < 99) ? FUNC_DELETE : FUNC_CLEAR;
               end
            endcase
            // Mostly pool values so lookups and deletes hit; some fresh patterns and extremes.
            r = $urandom_range(99);
            v = (r < 85) ? value_pool[$urandom_range(POOL_SIZE - 1)] :
                (r < 95) ? VALUE_W'($urandom) : value_pool[$urandom_range(3)];
            send_item(f, v);
         end
      end

      // Wind down: collect everything, then watch a while longer for stray responses.
      drain_results();
      repeat (END_SETTLE) @(posedge clock);

      $display("Run covered %0d transactions: %0d lookups, %0d inserts, %0d deletes, %0d clears.",
               items_sent, op_tally[FUNC_LOOKUP], op_tally[FUNC_INSERT],
               op_tally[FUNC_DELETE], op_tally[FUNC_CLEAR]);
      $display("Responses checked: %0d; inserts refused at capacity: %0d; largest count: %0d.",
               results_checked, full_rejects, peak_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #12ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
